// ----- sv/wav_stream_to_pcm16_macros.svh -----
// assertion macros shared by the port checker
`ifndef WAV_STREAM_TO_PCM16_MACROS_SVH
`define WAV_STREAM_TO_PCM16_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define WSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wsp_pkg.sv -----
// types, codes and constants of the wav byte stream parser
`default_nettype none

package wsp_pkg;

    localparam logic [31:0] MIN_FILE_LEN  = 32'd44;
    localparam logic [31:0] FIRST_CHUNK   = 32'd12;
    localparam logic [31:0] EARLIEST_DATA = 32'd36;
    localparam logic [31:0] DATA_ID       = 32'h6174_6164;
    localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;
    localparam logic [14:0] FULL_SCALE    = 15'd32767;

    typedef enum logic [1:0] {
        W_NONE  = 2'd0,
        W_PCM16 = 2'd1,
        W_PCM24 = 2'd2,
        W_F32   = 2'd3
    } t_width;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_NO_DATA     = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] pcm_sample;
        logic [2:0]         status;
        logic [15:0]        wave_format;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
        logic [15:0]        sample_bits;
        logic [31:0]        samples_out;
        logic               last_of_run;
    } t_out;

    typedef struct packed {
        logic        has_sample;
        logic        is_final;
        t_width      width;
        logic [31:0] word;
        t_status     status;
        logic [15:0] fmt;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] count;
    } t_job;

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:    v = 8'h52;
            4'd1:    v = 8'h49;
            4'd2:    v = 8'h46;
            4'd3:    v = 8'h46;
            4'd8:    v = 8'h57;
            4'd9:    v = 8'h41;
            4'd10:   v = 8'h56;
            4'd11:   v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/wsp_queue.sv -----
// job queue between the parser front and the conversion back
`default_nettype none

module wsp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire wsp_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    output wsp_pkg::t_job      o_job,
    input  wire logic          i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    wsp_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsp_front.sv -----
// byte parser: magic, header fields, chunk walk and sample assembly
`default_nettype none

module wsp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire wsp_pkg::t_in  i_in_data,
    input  wire logic          i_q_full,
    output logic               o_push,
    output wsp_pkg::t_job      o_job
);

    logic [31:0] r_pos;
    logic        r_magic;
    logic [15:0] r_fmt;
    logic [15:0] r_chan;
    logic [31:0] r_rate;
    logic [15:0] r_bits;
    logic [31:0] r_ncs;
    logic [63:0] r_hdr;
    logic        r_seen;
    logic        r_found;
    logic [31:0] r_rem;
    logic [31:0] r_asm;
    logic [1:0]  r_nbytes;
    logic [31:0] r_emitted;

    logic [31:0] n_pos;
    logic        n_magic;
    logic [15:0] n_fmt;
    logic [15:0] n_chan;
    logic [31:0] n_rate;
    logic [15:0] n_bits;
    logic [31:0] n_ncs;
    logic [63:0] n_hdr;
    logic        n_seen;
    logic        n_found;
    logic [31:0] n_rem;
    logic [31:0] n_asm;
    logic [1:0]  n_nbytes;
    logic [31:0] n_emitted;

    logic              accept;
    logic              emit;
    logic              fin;
    logic [7:0]        b;
    wsp_pkg::t_width   width;
    wsp_pkg::t_status  status;
    logic [31:0]       hdr_off;
    logic [31:0]       asm_new;
    logic [32:0]       nx;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign b          = i_in_data.file_byte;
    assign fin        = i_in_data.is_final;

    always_comb begin
        n_pos     = (r_pos != wsp_pkg::POS_MAX) ? r_pos + 32'd1 : r_pos;
        n_magic   = r_magic;
        n_fmt     = r_fmt;
        n_chan    = r_chan;
        n_rate    = r_rate;
        n_bits    = r_bits;
        n_ncs     = r_ncs;
        n_hdr     = r_hdr;
        n_seen    = r_seen;
        n_found   = r_found;
        n_rem     = r_rem;
        n_asm     = r_asm;
        n_nbytes  = r_nbytes;
        n_emitted = r_emitted;
        emit      = 1'b0;
        nx        = '0;

        if (r_fmt == 16'd1 && r_bits == 16'd16) begin
            width = wsp_pkg::W_PCM16;
        end else if (r_fmt == 16'd1 && r_bits == 16'd24) begin
            width = wsp_pkg::W_PCM24;
        end else if (r_fmt == 16'd3 && r_bits == 16'd32) begin
            width = wsp_pkg::W_F32;
        end else begin
            width = wsp_pkg::W_NONE;
        end

        if (r_pos < 32'd4 || (r_pos >= 32'd8 && r_pos < 32'd12)) begin
            if (b != wsp_pkg::magic_byte(r_pos[3:0])) begin
                n_magic = 1'b0;
            end
        end
        if (r_pos == 32'd20) n_fmt[7:0]   = b;
        if (r_pos == 32'd21) n_fmt[15:8]  = b;
        if (r_pos == 32'd22) n_chan[7:0]  = b;
        if (r_pos == 32'd23) n_chan[15:8] = b;
        if (r_pos >= 32'd24 && r_pos < 32'd28) begin
            n_rate[{r_pos[1:0], 3'b000} +: 8] = b;
        end
        if (r_pos == 32'd34) n_bits[7:0]  = b;
        if (r_pos == 32'd35) n_bits[15:8] = b;

        hdr_off = r_pos - r_ncs;
        asm_new = r_asm | ({24'd0, b} << {r_nbytes, 3'b000});

        if (r_found) begin
            if (r_rem != 32'd0) begin
                n_rem  = r_rem - 32'd1;
                n_seen = 1'b1;
                if (n_magic && width != wsp_pkg::W_NONE &&
                    r_ncs >= wsp_pkg::EARLIEST_DATA) begin
                    if (r_nbytes == 2'(width)) begin
                        emit      = 1'b1;
                        n_emitted = r_emitted + 32'd1;
                        n_asm     = '0;
                        n_nbytes  = '0;
                    end else begin
                        n_asm    = asm_new;
                        n_nbytes = r_nbytes + 2'd1;
                    end
                end
            end
        end else if (r_pos != wsp_pkg::POS_MAX && r_pos >= r_ncs && hdr_off < 32'd8) begin
            n_hdr = ((hdr_off[2:0] == 3'd0) ? 64'd0 : r_hdr) |
                    ({56'd0, b} << {hdr_off[2:0], 3'b000});
            if (hdr_off[2:0] == 3'd7) begin
                if (n_hdr[31:0] == wsp_pkg::DATA_ID) begin
                    n_found = 1'b1;
                    n_rem   = n_hdr[63:32];
                end else begin
                    nx = {1'b0, r_ncs} + 33'd8 + {1'b0, n_hdr[63:32]} + {32'd0, n_hdr[32]};
                    n_ncs = nx[32] ? 32'd0 : nx[31:0];
                end
            end
        end

        priority if (r_pos < wsp_pkg::MIN_FILE_LEN - 32'd1) begin
            status = wsp_pkg::ST_SHORT;
        end else if (!n_magic) begin
            status = wsp_pkg::ST_BAD_MAGIC;
        end else if (!n_seen) begin
            status = wsp_pkg::ST_NO_DATA;
        end else if (n_ncs < wsp_pkg::EARLIEST_DATA || width == wsp_pkg::W_NONE) begin
            status = wsp_pkg::ST_UNSUPPORTED;
        end else begin
            status = wsp_pkg::ST_OK;
        end
    end

    assign o_push           = accept && (emit || fin);
    assign o_job.has_sample = emit;
    assign o_job.is_final   = fin;
    assign o_job.width      = width;
    assign o_job.word       = asm_new;
    assign o_job.status     = status;
    assign o_job.fmt        = n_fmt;
    assign o_job.chan       = n_chan;
    assign o_job.rate       = n_rate;
    assign o_job.bits       = n_bits;
    assign o_job.count      = n_emitted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && fin)) begin
            r_pos     <= '0;
            r_magic   <= 1'b1;
            r_fmt     <= '0;
            r_chan    <= '0;
            r_rate    <= '0;
            r_bits    <= '0;
            r_ncs     <= wsp_pkg::FIRST_CHUNK;
            r_hdr     <= '0;
            r_seen    <= 1'b0;
            r_found   <= 1'b0;
            r_rem     <= '0;
            r_asm     <= '0;
            r_nbytes  <= '0;
            r_emitted <= '0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_magic   <= n_magic;
            r_fmt     <= n_fmt;
            r_chan    <= n_chan;
            r_rate    <= n_rate;
            r_bits    <= n_bits;
            r_ncs     <= n_ncs;
            r_hdr     <= n_hdr;
            r_seen    <= n_seen;
            r_found   <= n_found;
            r_rem     <= n_rem;
            r_asm     <= n_asm;
            r_nbytes  <= n_nbytes;
            r_emitted <= n_emitted;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsp_back.sv -----
// result issue, sample conversion pipeline and output register
`default_nettype none

module wsp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire wsp_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output wsp_pkg::t_out      o_out_data
);

    typedef struct packed {
        wsp_pkg::t_out   res;
        wsp_pkg::t_width width;
        logic            sgn;
        logic [7:0]      expo;
        logic [22:0]     mant;
        logic [38:0]     prod;
        logic [15:0]     raw;
    } t_s1;

    t_s1           r_s1;
    logic          r_s1_valid;
    wsp_pkg::t_out r_out;
    logic          r_out_valid;
    logic          r_phase;

    t_s1           n_s1;
    wsp_pkg::t_out n_out;
    wsp_pkg::t_kind issue_kind;
    logic          s1_free;
    logic          s2_free;
    logic          issue;

    logic [23:0]   q;
    logic          rnd;
    logic [24:0]   qr;
    logic [39:0]   rr;
    logic [7:0]    se;
    logic [39:0]   shifted;
    logic [15:0]   mag;
    logic [15:0]   fconv;
    logic [15:0]   full16;

    assign s2_free    = !r_out_valid || i_out_ready;
    assign s1_free    = !r_s1_valid || s2_free;
    assign issue      = i_valid && s1_free;
    assign issue_kind = (i_job.has_sample && !r_phase) ? wsp_pkg::KIND_SAMPLE
                                                      : wsp_pkg::KIND_STATUS;
    assign o_pop      = issue && (issue_kind == wsp_pkg::KIND_STATUS || !i_job.is_final);
    assign full16     = {1'b0, wsp_pkg::FULL_SCALE};

    always_comb begin
        n_s1.res.kind          = issue_kind;
        n_s1.res.pcm_sample    = '0;
        n_s1.res.status        = (issue_kind == wsp_pkg::KIND_STATUS) ? i_job.status
                                                                      : wsp_pkg::ST_OK;
        n_s1.res.wave_format   = i_job.fmt;
        n_s1.res.channel_count = i_job.chan;
        n_s1.res.rate_hz       = i_job.rate;
        n_s1.res.sample_bits   = i_job.bits;
        n_s1.res.samples_out   = i_job.count;
        n_s1.res.last_of_run   = (issue_kind == wsp_pkg::KIND_STATUS) || !i_job.is_final;
        n_s1.width             = (issue_kind == wsp_pkg::KIND_SAMPLE) ? i_job.width
                                                                      : wsp_pkg::W_NONE;
        n_s1.sgn               = i_job.word[31];
        n_s1.expo              = i_job.word[30:23];
        n_s1.mant              = i_job.word[22:0];
        n_s1.prod              = {15'd0, 1'b1, i_job.word[22:0]} * {24'd0, wsp_pkg::FULL_SCALE};
        n_s1.raw               = (i_job.width == wsp_pkg::W_PCM24) ? i_job.word[23:8]
                                                                   : i_job.word[15:0];
    end

    // round the product to 24 significant bits, then scale by the exponent
    always_comb begin
        if (r_s1.prod[38]) begin
            q   = r_s1.prod[38:15];
            rnd = r_s1.prod[14] && ((r_s1.prod[13:0] != '0) || r_s1.prod[15]);
        end else begin
            q   = r_s1.prod[37:14];
            rnd = r_s1.prod[13] && ((r_s1.prod[12:0] != '0) || r_s1.prod[14]);
        end
        qr      = {1'b0, q} + {24'd0, rnd};
        rr      = r_s1.prod[38] ? {qr, 15'd0} : {1'b0, qr, 14'd0};
        se      = 8'd150 - r_s1.expo;
        shifted = rr >> se[5:0];
        mag     = (se >= 8'd40) ? 16'd0 : shifted[15:0];

        priority if (r_s1.expo == 8'hFF && r_s1.mant != '0) begin
            fconv = full16;
        end else if (r_s1.expo >= 8'd127) begin
            fconv = r_s1.sgn ? 16'd0 - full16 : full16;
        end else if (r_s1.expo == 8'd0) begin
            fconv = 16'd0;
        end else begin
            fconv = r_s1.sgn ? 16'd0 - mag : mag;
        end

        n_out = r_s1.res;
        unique case (r_s1.width)
            wsp_pkg::W_PCM16: n_out.pcm_sample = r_s1.raw;
            wsp_pkg::W_PCM24: n_out.pcm_sample = r_s1.raw;
            wsp_pkg::W_F32:   n_out.pcm_sample = fconv;
            wsp_pkg::W_NONE:  n_out.pcm_sample = 16'sd0;
            default:          n_out.pcm_sample = 16'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= issue;
            end
            if (s2_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (issue) begin
                r_phase <= (issue_kind == wsp_pkg::KIND_SAMPLE) && i_job.is_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= n_s1;
        end
        if (s2_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- sv/wav_stream_to_pcm16.sv -----
// top level of the wav byte stream to signed 16-bit pcm converter
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    wsp_pkg::t_in  (file_byte, is_final)
// out      output     o_out_valid / i_out_ready  wsp_pkg::t_out (one result per transfer)
//
// one byte per cycle is taken while the job queue has room
// a result is registered in the queue, the multiply stage and the output register
// a byte that ends a sample and the file gives two results, a sample then a status
// synchronous reset clears the parser state, queue pointers and pipeline valids
// an output stall fills the queue; o_in_ready drops only when the queue is full
`default_nettype none

module wav_stream_to_pcm16 #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire wsp_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output wsp_pkg::t_out      o_out_data
);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    wsp_pkg::t_job push_job;
    wsp_pkg::t_job head_job;

    wsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    wsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    wsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sv/wsp_port_chk.sv -----
// port checker for the wav converter and its bind to the top level
`default_nettype none

`include "wav_stream_to_pcm16_macros.svh"

module wsp_port_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire wsp_pkg::t_in  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire wsp_pkg::t_out o_out_data
);

    `WSP_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data), "stalled input transfer changed")
    `WSP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")
    `WSP_ASSERT_NOW(a_status_closes, o_out_valid && (o_out_data.kind == wsp_pkg::KIND_STATUS), o_out_data.last_of_run && (o_out_data.pcm_sample == 16'sd0), "status result not last")
    `WSP_ASSERT_NOW(a_sample_counted, o_out_valid && (o_out_data.kind == wsp_pkg::KIND_SAMPLE), (o_out_data.status == wsp_pkg::ST_OK) && (o_out_data.samples_out != 32'd0), "sample result malformed")
    `WSP_ASSERT_NOW(a_status_range, o_out_valid, o_out_data.status <= wsp_pkg::ST_UNSUPPORTED, "status code out of range")

endmodule

bind wav_stream_to_pcm16 wsp_port_chk u_port_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the wav byte stream to pcm16 converter: random wav files, self-checked per transfer
`timescale 1ns / 1ps

module tb_top;
    import wsp_pkg::*;

    localparam int ITEM_TARGET    = 1050;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam logic [95:0] RIFF_WAVE = {"EVAW", 32'd0, "FFIR"};

    typedef enum int {
        FK_PCM16,
        FK_PCM24,
        FK_F32,
        FK_UNSUPPORTED,
        FK_BAD_MAGIC,
        FK_EARLY_DATA,
        FK_NO_DATA,
        FK_OVERFLOW,
        FK_SHORT,
        FK_NOISE
    } file_kind_e;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_BURSTY
    } rx_mode_e;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_in        byte_backlog[$];
    t_out       expected_results[$];
    logic [7:0] file_buf[$];

    logic        in_taken    = 1'b0;
    logic        out_taken   = 1'b0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int          mode_left   = 0;
    rx_mode_e    rx_mode     = RX_FREE;
    t_out        want;

    logic [31:0] wp_pos;
    logic        wp_magic_ok;
    logic [15:0] wp_fmt;
    logic [15:0] wp_chan;
    logic [31:0] wp_rate;
    logic [15:0] wp_bits;
    logic [31:0] wp_next_chunk;
    logic [63:0] wp_chunk_hdr;
    logic        wp_data_seen;
    logic        wp_in_data;
    logic [31:0] wp_data_left;
    logic [31:0] wp_assembly;
    int          wp_fill;
    logic [31:0] wp_count;

    wav_stream_to_pcm16 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic clear_parser();
        wp_pos        = '0;
        wp_magic_ok   = 1'b1;
        wp_fmt        = '0;
        wp_chan       = '0;
        wp_rate       = '0;
        wp_bits       = '0;
        wp_next_chunk = FIRST_CHUNK;
        wp_chunk_hdr  = '0;
        wp_data_seen  = 1'b0;
        wp_in_data    = 1'b0;
        wp_data_left  = '0;
        wp_assembly   = '0;
        wp_fill       = 0;
        wp_count      = '0;
    endtask

    function automatic logic [15:0] float_to_pcm16(input logic [31:0] f);
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] mag;
        int          len;
        int          sh;
        int          rsh;
        if (f[30:23] == 8'hFF && f[22:0] != 23'd0) return 16'(FULL_SCALE);
        if (f[30:23] >= 8'd127) return f[31] ? -16'(FULL_SCALE) : 16'(FULL_SCALE);
        if (f[30:23] == 8'd0) return 16'd0;
        prod = {40'd0, 1'b1, f[22:0]} * 64'(FULL_SCALE);
        len = 0;
        for (int i = 0; i < 64; i++) begin
            if (prod[i]) len = i + 1;
        end
        // round the product to 24 significant bits, ties to even
        if (len > 24) begin
            sh   = len - 24;
            q    = prod >> sh;
            rem  = prod & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            prod = q << sh;
        end
        rsh = 150 - int'(f[30:23]);
        mag = (rsh >= 64) ? 32'd0 : 32'(prod >> rsh);
        return f[31] ? 16'(-mag) : mag[15:0];
    endfunction

    function automatic t_out make_result(input t_kind k, input logic [15:0] pcm,
                                         input t_status st, input logic last);
        t_out r;
        r.kind          = k;
        r.pcm_sample    = pcm;
        r.status        = st;
        r.wave_format   = wp_fmt;
        r.channel_count = wp_chan;
        r.rate_hz       = wp_rate;
        r.sample_bits   = wp_bits;
        r.samples_out   = wp_count;
        r.last_of_run   = last;
        return r;
    endfunction

    task automatic parse_wav_byte(input t_in item);
        t_width      w;
        t_status     st;
        logic [31:0] at;
        logic [31:0] off;
        logic [31:0] csize;
        logic [63:0] nx;
        logic [15:0] pcm;
        logic [7:0]  b;
        at = wp_pos;
        b  = item.file_byte;
        if (wp_fmt == 16'd1 && wp_bits == 16'd16) w = W_PCM16;
        else if (wp_fmt == 16'd1 && wp_bits == 16'd24) w = W_PCM24;
        else if (wp_fmt == 16'd3 && wp_bits == 16'd32) w = W_F32;
        else w = W_NONE;

        if ((at < 32'd4 || (at >= 32'd8 && at < 32'd12)) && b != RIFF_WAVE[8 * at +: 8])
            wp_magic_ok = 1'b0;
        case (at)
            32'd20: wp_fmt[7:0]   = b;
            32'd21: wp_fmt[15:8]  = b;
            32'd22: wp_chan[7:0]  = b;
            32'd23: wp_chan[15:8] = b;
            32'd24, 32'd25, 32'd26, 32'd27: wp_rate[8 * (at - 32'd24) +: 8] = b;
            32'd34: wp_bits[7:0]  = b;
            32'd35: wp_bits[15:8] = b;
            default: ;
        endcase

        if (wp_in_data) begin
            if (wp_data_left != 32'd0) begin
                wp_data_left = wp_data_left - 32'd1;
                wp_data_seen = 1'b1;
                if (wp_magic_ok && w != W_NONE && wp_next_chunk >= EARLIEST_DATA) begin
                    wp_assembly[8 * wp_fill +: 8] = b;
                    wp_fill++;
                    if (wp_fill == int'(w) + 1) begin
                        case (w)
                            W_PCM16: pcm = wp_assembly[15:0];
                            W_PCM24: pcm = wp_assembly[23:8];
                            default: pcm = float_to_pcm16(wp_assembly);
                        endcase
                        wp_count = wp_count + 32'd1;
                        expected_results.push_back(
                            make_result(KIND_SAMPLE, pcm, ST_OK, !item.is_final));
                        wp_assembly = '0;
                        wp_fill     = 0;
                    end
                end
            end
        end else if (at != POS_MAX && at >= wp_next_chunk && at - wp_next_chunk < 32'd8) begin
            off = at - wp_next_chunk;
            if (off == 32'd0) wp_chunk_hdr = '0;
            wp_chunk_hdr[8 * off +: 8] = b;
            if (off == 32'd7) begin
                csize = wp_chunk_hdr[63:32];
                if (wp_chunk_hdr[31:0] == DATA_ID) begin
                    wp_in_data   = 1'b1;
                    wp_data_left = csize;
                end else begin
                    nx = 64'(wp_next_chunk) + 64'd8 + 64'(csize) + 64'(csize[0]);
                    wp_next_chunk = (nx > 64'hFFFF_FFFF) ? 32'd0 : nx[31:0];
                end
            end
        end

        if (wp_pos != POS_MAX) wp_pos = wp_pos + 32'd1;

        if (item.is_final) begin
            if (at < MIN_FILE_LEN - 32'd1) st = ST_SHORT;
            else if (!wp_magic_ok) st = ST_BAD_MAGIC;
            else if (!wp_data_seen) st = ST_NO_DATA;
            else if (wp_next_chunk < EARLIEST_DATA || w == W_NONE) st = ST_UNSUPPORTED;
            else st = ST_OK;
            expected_results.push_back(make_result(KIND_STATUS, 16'd0, st, 1'b1));
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_buf.push_back(v[8 * i +: 8]);
    endtask

    task automatic add_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_buf.push_back(t[8 * i +: 8]);
    endtask

    task automatic add_fmt_fields(input logic [15:0] fmt, input logic [15:0] chan,
                                  input logic [31:0] rate, input logic [15:0] bits);
        add_le(fmt, 2);
        add_le(chan, 2);
        add_le(rate, 4);
        add_le($urandom, 4);
        add_le($urandom, 2);
        add_le(bits, 2);
    endtask

    function automatic logic [31:0] pick_float();
        logic        s;
        logic [22:0] m;
        s = 1'($urandom_range(0, 1));
        m = 23'($urandom);
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return {s, 8'hFF, m | 23'd1};
            2:       return {s, 8'hFF, 23'd0};
            3:       return {s, 8'($urandom_range(127, 254)), m};
            4:       return {s, 31'd0};
            5:       return {s, 8'h00, m};
            6:       return {s, 8'($urandom_range(1, 126)), m};
            default: return {s, 8'($urandom_range(110, 126)), m};
        endcase
    endfunction

    task automatic queue_file();
        t_in item;
        foreach (file_buf[i]) begin
            item.file_byte = file_buf[i];
            item.is_final  = (i == file_buf.size() - 1);
            byte_backlog.push_back(item);
        end
        file_buf.delete();
    endtask

    task automatic make_file(input file_kind_e kind);
        logic [15:0] fmt;
        logic [15:0] bits;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [31:0] csize;
        int          nbytes;
        int          span;
        int          fsize;
        int          idx;
        file_buf.delete();
        chan = $urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom);
        rate = $urandom_range(0, 1) ? 32'd48000 : $urandom;
        fmt  = 16'd1;
        bits = 16'd16;
        nbytes = 2;
        case (kind)
            FK_PCM24: begin
                bits   = 16'd24;
                nbytes = 3;
            end
            FK_F32: begin
                fmt    = 16'd3;
                bits   = 16'd32;
                nbytes = 4;
            end
            FK_UNSUPPORTED: begin
                fmt  = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : 16'($urandom);
                bits = $urandom_range(0, 1) ? 16'(8 * $urandom_range(0, 8)) : 16'($urandom);
                nbytes = $urandom_range(1, 4);
            end
            default: ;
        endcase

        if (kind == FK_NOISE) begin
            if ($urandom_range(0, 1)) add_tag("RIFF");
            repeat ($urandom_range(1, 90)) add_le($urandom, 1);
        end else begin
            add_tag("RIFF");
            add_le($urandom, 4);
            add_tag("WAVE");
            if (kind == FK_BAD_MAGIC) begin
                idx = $urandom_range(0, 7);
                if (idx > 3) idx = idx + 4;
                file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
            end
            if (kind == FK_EARLY_DATA) begin
                if ($urandom_range(0, 1)) begin
                    add_tag("data");
                    add_le($urandom_range(16, 48), 4);
                    add_fmt_fields(fmt, chan, rate, bits);
                end else begin
                    add_tag("fmt ");
                    add_le(32'd4, 4);
                    add_le($urandom, 4);
                    add_tag("data");
                    add_le($urandom_range(12, 40), 4);
                end
                repeat ($urandom_range(4, 30)) add_le($urandom, 1);
            end else begin
                case ($urandom_range(0, 7))
                    0:       fsize = 18;
                    1:       fsize = 17;
                    2:       fsize = 27;
                    default: fsize = 16;
                endcase
                add_tag("fmt ");
                add_le(fsize, 4);
                add_fmt_fields(fmt, chan, rate, bits);
                repeat (fsize - 16 + fsize % 2) add_le($urandom, 1);
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 2)) begin
                        add_tag("LIST");
                        csize = $urandom_range(0, 9);
                        add_le(csize, 4);
                        repeat (csize + csize[0]) add_le($urandom, 1);
                    end
                end
                if (kind == FK_OVERFLOW) begin
                    add_tag("JUNK");
                    add_le(32'hFFFF_FF00 | $urandom_range(0, 255), 4);
                end
                add_tag("data");
                if (kind == FK_NO_DATA) begin
                    if ($urandom_range(0, 1)) begin
                        add_le(32'd0, 4);
                        repeat ($urandom_range(0, 6)) add_le($urandom, 1);
                    end else begin
                        add_le($urandom_range(1, 64), 4);
                    end
                end else begin
                    csize = $urandom_range(0, 6) * nbytes;
                    if ($urandom_range(0, 3) == 0) csize = csize + $urandom_range(0, nbytes - 1);
                    add_le(csize, 4);
                    case ($urandom_range(0, 5))
                        0:       span = $urandom_range(0, csize);
                        1:       span = csize + $urandom_range(1, 6);
                        default: span = csize;
                    endcase
                    idx = file_buf.size() + span;
                    // whole words, trimmed back to the payload length
                    repeat ((span + 3) / 4) add_le((kind == FK_F32) ? pick_float() : $urandom, 4);
                    while (file_buf.size() > idx) file_buf.delete(file_buf.size() - 1);
                end
            end
            if (kind == FK_SHORT) begin
                idx = $urandom_range(1, 43);
                while (file_buf.size() > idx) file_buf.delete(file_buf.size() - 1);
            end else if ($urandom_range(0, 11) == 0) begin
                idx = $urandom_range(0, file_buf.size() - 1);
                file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
            end
        end
        queue_file();
    endtask

    // sample on the rising edge: predict accepted bytes, check accepted results
    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (in_taken) parse_wav_byte(i_in_data);
        if (out_taken) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, o_out_data.kind);
                check_field("pcm_sample", want.pcm_sample, o_out_data.pcm_sample);
                check_field("status", want.status, o_out_data.status);
                check_field("wave_format", want.wave_format, o_out_data.wave_format);
                check_field("channel_count", want.channel_count, o_out_data.channel_count);
                check_field("rate_hz", want.rate_hz, o_out_data.rate_hz);
                check_field("sample_bits", want.sample_bits, o_out_data.sample_bits);
                check_field("samples_out", want.samples_out, o_out_data.samples_out);
                check_field("last_of_run", want.last_of_run, o_out_data.last_of_run);
            end
        end
        if (in_taken || out_taken) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // drive on the falling edge: bursty sender, receiver with its own stall pattern
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
                i_in_data  <= byte_backlog.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end

        if (mode_left == 0) begin
            rx_mode   = rx_mode_e'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: i_out_ready <= 1'b1;
                RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        clear_parser();
        add_le(8'h00, 1);
        queue_file();
        add_le(8'hFF, 1);
        queue_file();
        add_tag("RIFF");
        add_le(32'hFFFF_FFFF, 4);
        add_tag("WAVE");
        add_le(32'h0000_0000, 4);
        add_le(32'hFFFF_FFFF, 4);
        queue_file();
        for (int k = 0; k <= int'(FK_NOISE); k++) make_file(file_kind_e'(k));
        while (byte_backlog.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 6) make_file(file_kind_e'($urandom_range(0, 2)));
            else make_file(file_kind_e'($urandom_range(3, int'(FK_NOISE))));
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/wsp_pkg.sv
sv/wsp_queue.sv
sv/wsp_front.sv
sv/wsp_back.sv
sv/wav_stream_to_pcm16.sv
sv/wsp_port_chk.sv
tb/tb_top.sv
